FILE: hw/rtl/tbpm_pkg.sv
package tbpm_pkg;

    localparam int NB_COUNT = 8;
    localparam int NB_W     = 3;
    localparam int IDX_W    = 8;
    localparam int MASK_W   = 4;
    localparam int CNT_W    = 4;
    localparam int BEATS    = NB_COUNT + 1;

    // corner bits
    localparam logic [MASK_W-1:0] NORTHWEST = 4'd8;
    localparam logic [MASK_W-1:0] NORTHEAST = 4'd4;
    localparam logic [MASK_W-1:0] SOUTHEAST = 4'd2;
    localparam logic [MASK_W-1:0] SOUTHWEST = 4'd1;
    localparam logic [MASK_W-1:0] FULL_MASK = 4'hf;

    // neighbor positions, inside_map bit order
    localparam logic [NB_W-1:0] NB_N  = 3'd0;
    localparam logic [NB_W-1:0] NB_NE = 3'd1;
    localparam logic [NB_W-1:0] NB_E  = 3'd2;
    localparam logic [NB_W-1:0] NB_SE = 3'd3;
    localparam logic [NB_W-1:0] NB_S  = 3'd4;
    localparam logic [NB_W-1:0] NB_SW = 3'd5;
    localparam logic [NB_W-1:0] NB_W_ = 3'd6;
    localparam logic [NB_W-1:0] NB_NW = 3'd7;

    // edge neighbors cover two corners, diagonals one
    function automatic logic [MASK_W-1:0] nb_corners(input logic [NB_W-1:0] pos);
        logic [MASK_W-1:0] m;
        case (pos)
            NB_N:    m = NORTHWEST | NORTHEAST;
            NB_NE:   m = NORTHEAST;
            NB_E:    m = NORTHEAST | SOUTHEAST;
            NB_SE:   m = SOUTHEAST;
            NB_S:    m = SOUTHWEST | SOUTHEAST;
            NB_SW:   m = SOUTHWEST;
            NB_W_:   m = SOUTHWEST | NORTHWEST;
            NB_NW:   m = NORTHWEST;
            default: m = '0;
        endcase
        return m;
    endfunction

    // sorted overlay list for one texel, descending index in slot 0 upward
    typedef struct packed {
        logic [NB_COUNT-1:0][IDX_W-1:0]  layer;
        logic [NB_COUNT-1:0][MASK_W-1:0] mask;
        logic [CNT_W-1:0]                count;
        logic [IDX_W-1:0]                center;
    } t_layer_set;

endpackage

FILE: hw/rtl/tbpm_if.sv
interface tbpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] center_index;
    logic [7:0] north_index;
    logic [7:0] northeast_index;
    logic [7:0] east_index;
    logic [7:0] southeast_index;
    logic [7:0] south_index;
    logic [7:0] southwest_index;
    logic [7:0] west_index;
    logic [7:0] northwest_index;
    logic [7:0] inside_map;

    modport source (
        output valid, center_index, north_index, northeast_index, east_index,
               southeast_index, south_index, southwest_index, west_index,
               northwest_index, inside_map,
        input  ready
    );
    modport sink (
        input  valid, center_index, north_index, northeast_index, east_index,
               southeast_index, south_index, southwest_index, west_index,
               northwest_index, inside_map,
        output ready
    );
endinterface

interface tbpm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] layer_index;
    logic [3:0] corner_mask;
    logic       is_base;
    logic       last;

    modport source (
        output valid, layer_index, corner_mask, is_base, last,
        input  ready
    );
    modport sink (
        input  valid, layer_index, corner_mask, is_base, last,
        output ready
    );
endinterface

FILE: hw/rtl/tbpm_serializer.sv
module tbpm_serializer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_set_valid,
    input  tbpm_pkg::t_layer_set  i_set,
    output logic                  o_set_ready,
    tbpm_out_if.source            o_out
);

    logic                             r_valid;
    logic                             r_base;
    logic [tbpm_pkg::CNT_W-1:0]       r_rem;   // beats left after the current one
    logic [tbpm_pkg::IDX_W-1:0]       r_layer [tbpm_pkg::BEATS];
    logic [tbpm_pkg::MASK_W-1:0]      r_mask  [tbpm_pkg::BEATS];
    logic                             w_fire;
    logic                             w_free;
    logic                             w_load;

    assign w_fire      = r_valid && o_out.ready;
    assign w_free      = !r_valid || (w_fire && (r_rem == '0));
    assign w_load      = i_set_valid && w_free;
    assign o_set_ready = w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (w_fire && (r_rem == '0)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_base     <= 1'b1;
            r_rem      <= i_set.count;
            r_layer[0] <= i_set.center;
            r_mask[0]  <= tbpm_pkg::FULL_MASK;
            for (int k = 0; k < tbpm_pkg::NB_COUNT; k++) begin
                r_layer[k+1] <= i_set.layer[k];
                r_mask[k+1]  <= i_set.mask[k];
            end
        end else if (w_fire) begin
            r_base <= 1'b0;
            r_rem  <= r_rem - 1'b1;
            for (int k = 0; k < tbpm_pkg::BEATS - 1; k++) begin
                r_layer[k] <= r_layer[k+1];
                r_mask[k]  <= r_mask[k+1];
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.layer_index = r_layer[0];
    assign o_out.corner_mask = r_mask[0];
    assign o_out.is_base     = r_base;
    assign o_out.last        = (r_rem == '0);

endmodule

FILE: hw/rtl/terrain_blend_patch_mask.sv
// Blend-layer planner for one terrain texel.
// Input channel i_in: one beat per texel with the center material index, the
// eight neighbor indices and inside_map (bit 0 = N, then NE, E, SE, S, SW, W, NW).
// Output channel o_out: per texel, first the base beat (center index, mask 15,
// is_base = 1), then one beat per distinct in-map neighbor index below the
// center, in descending index order, with its corner mask (NW=8 NE=4 SE=2 SW=1).
// last marks the final beat of a texel. A texel yields 1 to 9 beats.
// Path: the input beat is registered in stage 1, then passes stages 2 to 4
// and the output shift register in turn, where the base beat is first valid;
// a stall on o_out can hold the texel at any of them.
// Throughput: the pipeline takes a texel every cycle while i_in.ready is high;
// the output sends one beat per cycle while o_out.ready is high; a texel with
// n overlays takes n + 1 beats. Sustained rate is set by the output register.
// A stall on o_out freezes the output beat; the stages behind it fill and
// then i_in.ready drops. Nothing is dropped or repeated.
// Reset (synchronous, active low) empties all stages; no beat is pending after.
module terrain_blend_patch_mask (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbpm_in_if.sink    i_in,
    tbpm_out_if.source o_out
);

    localparam int N  = tbpm_pkg::NB_COUNT;
    localparam int IW = tbpm_pkg::IDX_W;
    localparam int MW = tbpm_pkg::MASK_W;

    // handshake chain, back to front
    logic w_ser_rdy;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // input fields in neighbor order
    logic [IW-1:0] w_nb   [N];
    logic [N-1:0]  w_cand;

    // stage 1: neighbors that are in the map and below the center
    logic          r1_v;
    logic [IW-1:0] r1_center;
    logic [IW-1:0] r1_nb [N];
    logic [N-1:0]  r1_cand;

    // stage 2: merged corner masks, first occurrence of each index kept
    logic          r2_v;
    logic [IW-1:0] r2_center;
    logic [IW-1:0] r2_nb   [N];
    logic [MW-1:0] r2_mask [N];
    logic [N-1:0]  r2_keep;
    logic [MW-1:0] w2_mask [N];
    logic [N-1:0]  w2_keep;

    // stage 3: rank of each kept index among the kept ones (0 = largest)
    logic                            r3_v;
    logic [IW-1:0]                   r3_center;
    logic [IW-1:0]                   r3_nb   [N];
    logic [MW-1:0]                   r3_mask [N];
    logic [N-1:0]                    r3_keep;
    logic [tbpm_pkg::NB_W-1:0]       r3_rank [N];
    logic [tbpm_pkg::CNT_W-1:0]      r3_count;
    logic [tbpm_pkg::NB_W-1:0]       w3_rank [N];
    logic [tbpm_pkg::CNT_W-1:0]      w3_count;

    // stage 4: overlays scattered into sorted slots
    logic                  r4_v;
    tbpm_pkg::t_layer_set  r4_set;
    tbpm_pkg::t_layer_set  w4_set;

    assign w_rdy4     = !r4_v || w_ser_rdy;
    assign w_rdy3     = !r3_v || w_rdy4;
    assign w_rdy2     = !r2_v || w_rdy3;
    assign w_rdy1     = !r1_v || w_rdy2;
    assign i_in.ready = w_rdy1;

    assign w_nb[0] = i_in.north_index;
    assign w_nb[1] = i_in.northeast_index;
    assign w_nb[2] = i_in.east_index;
    assign w_nb[3] = i_in.southeast_index;
    assign w_nb[4] = i_in.south_index;
    assign w_nb[5] = i_in.southwest_index;
    assign w_nb[6] = i_in.west_index;
    assign w_nb[7] = i_in.northwest_index;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_cand[i] = i_in.inside_map[i] && (w_nb[i] < i_in.center_index);
        end
    end

    // duplicates: OR the corners of every candidate with the same index,
    // keep only the lowest-numbered position of that index
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w2_keep[i] = r1_cand[i];
            w2_mask[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (r1_cand[j] && (r1_nb[j] == r1_nb[i])) begin
                    w2_mask[i] = w2_mask[i] | tbpm_pkg::nb_corners(tbpm_pkg::NB_W'(j));
                    if (j < i) begin
                        w2_keep[i] = 1'b0;
                    end
                end
            end
        end
    end

    // kept indices are distinct, so the count of larger ones is a unique slot
    always_comb begin
        w3_count = '0;
        for (int i = 0; i < N; i++) begin
            w3_rank[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (r2_keep[j] && (r2_nb[j] > r2_nb[i])) begin
                    w3_rank[i] = w3_rank[i] + 1'b1;
                end
            end
            if (r2_keep[i]) begin
                w3_count = w3_count + 1'b1;
            end
        end
    end

    always_comb begin
        w4_set        = '0;
        w4_set.center = r3_center;
        w4_set.count  = r3_count;
        for (int r = 0; r < N; r++) begin
            for (int i = 0; i < N; i++) begin
                if (r3_keep[i] && (r3_rank[i] == tbpm_pkg::NB_W'(r))) begin
                    w4_set.layer[r] = w4_set.layer[r] | r3_nb[i];
                    w4_set.mask[r]  = w4_set.mask[r]  | r3_mask[i];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_in.valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in.valid) begin
            r1_center <= i_in.center_index;
            r1_nb     <= w_nb;
            r1_cand   <= w_cand;
        end
        if (w_rdy2 && r1_v) begin
            r2_center <= r1_center;
            r2_nb     <= r1_nb;
            r2_mask   <= w2_mask;
            r2_keep   <= w2_keep;
        end
        if (w_rdy3 && r2_v) begin
            r3_center <= r2_center;
            r3_nb     <= r2_nb;
            r3_mask   <= r2_mask;
            r3_keep   <= r2_keep;
            r3_rank   <= w3_rank;
            r3_count  <= w3_count;
        end
        if (w_rdy4 && r3_v) begin
            r4_set <= w4_set;
        end
    end

    tbpm_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set_valid (r4_v),
        .i_set       (r4_set),
        .o_set_ready (w_ser_rdy),
        .o_out       (o_out)
    );

endmodule

FILE: hw/rtl/tbpm_chk.sv
module tbpm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_layer_index,
    input logic [3:0] i_corner_mask,
    input logic       i_is_base,
    input logic       i_last
);

    logic       r_expect_base;
    logic [7:0] r_prev_layer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_base <= 1'b1;
        end else if (i_out_valid && i_out_ready) begin
            r_expect_base <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_valid && i_out_ready) begin
            r_prev_layer <= i_layer_index;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_layer_index)
            && $stable(i_corner_mask) && $stable(i_is_base) && $stable(i_last))
        else $error("output beat changed under stall");

    a_base_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_base == r_expect_base))
        else $error("base beat out of place");

    a_base_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_base |-> (i_corner_mask == 4'hf))
        else $error("base beat without full mask");

    a_descend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_base && !r_expect_base |-> (i_layer_index < r_prev_layer))
        else $error("overlay not below previous layer");

    a_overlay_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_base |-> (i_corner_mask != 4'h0))
        else $error("overlay with empty mask");

endmodule

bind terrain_blend_patch_mask tbpm_chk u_tbpm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_layer_index (o_out.layer_index),
    .i_corner_mask (o_out.corner_mask),
    .i_is_base     (o_out.is_base),
    .i_last        (o_out.last)
);
